/* design/vatp_pkg.sv */
// ----------------------------------------------------------------------------
// vatp_pkg: shared types, constants and arithmetic helpers
// Stage map, CORDIC lane steps, rounding and the arctangent table used by the
// ray-to-pixel projection pipeline.
// ----------------------------------------------------------------------------
package vatp_pkg;

  localparam int CORDIC_STAGES = 16;

  // CORDIC segment: wrap, fold, iterations, unfold
  localparam int CL    = CORDIC_STAGES + 3;
  localparam int DL    = 33;  // divider: range check, 31 steps, sign
  localparam int SL    = 31;  // square root steps

  localparam int P_C1  = 1;
  localparam int P_M1  = P_C1 + CL;
  localparam int P_M2  = P_M1 + 1;
  localparam int P_M3  = P_M2 + 1;
  localparam int P_C2  = P_M3 + 1;
  localparam int P_T0  = P_C2 + CL;
  localparam int P_T1  = P_T0 + 1;
  localparam int P_T2  = P_T1 + 1;
  localparam int P_D1  = P_T2 + 1;
  localparam int P_Q0  = P_D1 + DL;
  localparam int P_Q1  = P_Q0 + 1;
  localparam int P_S   = P_Q1 + 1;
  localparam int P_U1  = P_S + SL;
  localparam int P_U2  = P_U1 + 1;
  localparam int P_D2  = P_U2 + 1;
  localparam int P_Z   = P_D2 + DL;
  localparam int NSTG  = P_Z + 1;

  localparam logic [1:0] REG_ROLL  = 2'd0;
  localparam logic [1:0] REG_FOCAL = 2'd1;
  localparam logic [1:0] REG_CX    = 2'd2;
  localparam logic [1:0] REG_CY    = 2'd3;

  localparam logic signed [33:0] C_PI     = 34'sd3373259426;
  localparam logic signed [33:0] C_HPI    = 34'sd1686629713;
  localparam logic signed [33:0] C_TWO_PI = 34'sd6746518852;
  localparam logic signed [31:0] C_GAIN   = 32'sd652032874;
  localparam logic signed [15:0] C_GATE   = 16'sd12868;
  localparam logic [30:0]        C_TLIM   = 31'h40000000;
  localparam logic signed [32:0] C_PMAX   = 33'sd8388607;
  localparam logic signed [32:0] C_PMIN   = -33'sd8388608;

  typedef struct packed {
    logic signed [33:0] a;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               n;
  } lane_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic               inview;
    lane_t [1:0]        ln;
    logic signed [47:0] p0;
    logic signed [47:0] p1;
    logic signed [47:0] p2;
    logic signed [47:0] p3;
    logic signed [48:0] t0;
    logic signed [48:0] t1;
    logic [1:0][31:0]   s;
    logic [1:0][31:0]   c;
    logic [1:0]         g;
    logic [63:0]        nn;
    logic [30:0]        q;
    logic               ovf;
    logic [30:0]        mag;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [61:0]        sa;
    logic [61:0]        sb;
    logic [61:0]        sr;
    logic [23:0]        ox;
    logic [23:0]        oy;
    logic               clip;
  } pl_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] k);
    case (k)
      5'd0:  return 31'd843314857;
      5'd1:  return 31'd497837829;
      5'd2:  return 31'd263043837;
      5'd3:  return 31'd133525159;
      5'd4:  return 31'd67021687;
      5'd5:  return 31'd33543516;
      5'd6:  return 31'd16775851;
      5'd7:  return 31'd8388437;
      5'd8:  return 31'd4194283;
      5'd9:  return 31'd2097149;
      5'd10: return 31'd1048576;
      5'd11: return 31'd524288;
      5'd12: return 31'd262144;
      5'd13: return 31'd131072;
      5'd14: return 31'd65536;
      5'd15: return 31'd32768;
      5'd16: return 31'd16384;
      5'd17: return 31'd8192;
      5'd18: return 31'd4096;
      5'd19: return 31'd2048;
      5'd20: return 31'd1024;
      5'd21: return 31'd512;
      5'd22: return 31'd256;
      5'd23: return 31'd128;
      5'd24: return 31'd64;
      5'd25: return 31'd32;
      5'd26: return 31'd16;
      5'd27: return 31'd8;
      5'd28: return 31'd4;
      5'd29: return 31'd2;
      5'd30: return 31'd1;
      default: return 31'd0;
    endcase
  endfunction

  function automatic lane_t cor_wrap(input lane_t l);
    lane_t r;
    r = l;
    if ($signed(l.a) > C_PI) begin
      r.a = l.a - C_TWO_PI;
    end else if ($signed(l.a) < -C_PI) begin
      r.a = l.a + C_TWO_PI;
    end
    return r;
  endfunction

  function automatic lane_t cor_fold(input lane_t l);
    lane_t r;
    r   = l;
    r.x = C_GAIN;
    r.y = '0;
    r.n = 1'b0;
    if ($signed(l.a) > C_HPI) begin
      r.a = l.a - C_PI;
      r.n = 1'b1;
    end else if ($signed(l.a) < -C_HPI) begin
      r.a = l.a + C_PI;
      r.n = 1'b1;
    end
    return r;
  endfunction

  function automatic lane_t cor_iter(input lane_t l, input logic [4:0] k);
    lane_t r;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [33:0] at;
    r  = l;
    dx = $signed(l.y) >>> k;
    dy = $signed(l.x) >>> k;
    at = $signed({3'b000, atan_q30(k)});
    if (!l.a[33]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.a = l.a - at;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.a = l.a + at;
    end
    return r;
  endfunction

  function automatic lane_t cor_unfold(input lane_t l);
    lane_t r;
    r = l;
    if (l.n) begin
      r.x = -l.x;
      r.y = -l.y;
    end
    return r;
  endfunction

  // Q13 x Q30 sum back to Q30, half away from zero
  function automatic logic signed [33:0] rnd13(input logic signed [48:0] v);
    logic [48:0] m;
    m = v[48] ? 49'(-v) : 49'(v);
    m = (m + 49'd4096) >> 13;
    return v[48] ? -$signed(m[33:0]) : $signed(m[33:0]);
  endfunction

endpackage

/* design/view_angles_to_pixel.sv */
// ----------------------------------------------------------------------------
// view_angles_to_pixel: ray yaw/pitch to rectilinear image pixel
// Fully pipelined roll rotation, CORDIC tangents, long division and square
// root, with saturation of the Q20.4 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (ray_yaw, ray_pitch) are taken on in_valid && in_ready and
//   each yields exactly one output beat (pixel_x, pixel_y, in_view, clipped)
//   on out_valid && out_ready, in order.
//   The path runs through two CORDIC segments of CORDIC_STAGES+3 stages,
//   two 33-stage dividers and a 31-stage square root, one bit per step.
//   Throughput is one beat per cycle while out_ready stays high.
//   The whole pipeline advances when the last stage is empty or taken, so a
//   stalled receiver holds every stage; in_ready drops only while the output
//   beat waits, and nothing is lost or repeated.
//   Registers are written through cfg_we/cfg_index/cfg_data with no wait;
//   write them only while the pipeline is empty.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (roll 0, focal length 11668, centre 0, 0).
// ----------------------------------------------------------------------------
module view_angles_to_pixel
  import vatp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] ray_yaw,
  input  logic signed [15:0] ray_pitch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] pixel_x,
  output logic signed [23:0] pixel_y,
  output logic               in_view,
  output logic               clipped
);

  logic signed [15:0] roll_angle;
  logic [19:0]        focal_length;
  logic [15:0]        centre_x;
  logic [15:0]        centre_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_angle   <= '0;
      focal_length <= 20'd11668;
      centre_x     <= '0;
      centre_y     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROLL:  roll_angle   <= cfg_data[15:0];
        REG_FOCAL: focal_length <= cfg_data;
        REG_CX:    centre_x     <= cfg_data[15:0];
        REG_CY:    centre_y     <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  logic            adv;
  logic [NSTG-1:0] vld;
  pl_t             st [NSTG];

  assign adv      = !vld[NSTG-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    pl_t n;

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i] <= n;
      end
    end

    if (i == 0) begin : g_in
      always_comb begin
        n        = '0;
        n.yaw    = ray_yaw;
        n.pitch  = ray_pitch;
        n.inview = (ray_yaw <= C_GATE) && (ray_yaw >= -C_GATE) &&
                   (ray_pitch <= C_GATE) && (ray_pitch >= -C_GATE);
        n.ln[0].a = {roll_angle[15], roll_angle, 17'd0};
      end
    end else if ((i >= P_C1 && i < P_C1 + CL) || (i >= P_C2 && i < P_C2 + CL)) begin : g_cor
      localparam int OFF = (i >= P_C2) ? i - P_C2 : i - P_C1;
      always_comb begin
        n = st[i-1];
        for (int l = 0; l < 2; l++) begin
          if (OFF == 0) begin
            n.ln[l] = cor_wrap(st[i-1].ln[l]);
          end else if (OFF == 1) begin
            n.ln[l] = cor_fold(st[i-1].ln[l]);
          end else if (OFF == CL - 1) begin
            n.ln[l] = cor_unfold(st[i-1].ln[l]);
          end else begin
            n.ln[l] = cor_iter(st[i-1].ln[l], 5'(OFF - 2));
          end
        end
      end
    end else if (i == P_M1) begin : g_m1
      always_comb begin
        n    = st[i-1];
        n.p0 = 48'(st[i-1].yaw) * 48'(st[i-1].ln[0].x);
        n.p1 = 48'(st[i-1].pitch) * 48'(st[i-1].ln[0].y);
        n.p2 = 48'(st[i-1].pitch) * 48'(st[i-1].ln[0].x);
        n.p3 = 48'(st[i-1].yaw) * 48'(st[i-1].ln[0].y);
      end
    end else if (i == P_M2) begin : g_m2
      always_comb begin
        n    = st[i-1];
        n.t0 = 49'(st[i-1].p0) + 49'(st[i-1].p1);
        n.t1 = 49'(st[i-1].p2) - 49'(st[i-1].p3);
      end
    end else if (i == P_M3) begin : g_m3
      always_comb begin
        n         = st[i-1];
        n.ln[0].a = rnd13(st[i-1].t0);
        n.ln[1].a = rnd13(st[i-1].t1);
      end
    end else if (i == P_T0) begin : g_t0
      always_comb begin
        n = st[i-1];
        for (int l = 0; l < 2; l++) begin
          n.s[l] = st[i-1].ln[l].y[31] ? 32'(-st[i-1].ln[l].y) : 32'(st[i-1].ln[l].y);
          n.c[l] = st[i-1].ln[l].x[31] ? 32'(-st[i-1].ln[l].x) : 32'(st[i-1].ln[l].x);
          if (st[i-1].ln[l].x == '0) begin
            n.c[l] = 32'd1;
          end
          n.g[l] = st[i-1].ln[l].y[31] ^ st[i-1].ln[l].x[31];
        end
      end
    end else if (i == P_T1) begin : g_t1
      always_comb begin
        n    = st[i-1];
        n.nn = 64'(focal_length) * 64'(st[i-1].s[0]);
      end
    end else if (i == P_T2 || i == P_U2) begin : g_rnd
      localparam int LN = (i == P_U2) ? 1 : 0;
      always_comb begin
        n    = st[i-1];
        n.nn = st[i-1].nn + 64'(st[i-1].c[LN] >> 1);
      end
    end else if ((i >= P_D1 && i < P_D1 + DL) || (i >= P_D2 && i < P_D2 + DL)) begin : g_div
      localparam int LN  = (i >= P_D2) ? 1 : 0;
      localparam int OFF = (i >= P_D2) ? i - P_D2 : i - P_D1;
      localparam int K   = (OFF >= 1 && OFF <= 31) ? 31 - OFF : 0;
      logic [63:0] dk;
      logic [30:0] m;
      logic [31:0] sv;
      always_comb begin
        n  = st[i-1];
        dk = 64'(st[i-1].c[LN]) << K;
        m  = (st[i-1].ovf || st[i-1].q > C_TLIM) ? C_TLIM : st[i-1].q;
        sv = st[i-1].g[LN] ? 32'd0 - {1'b0, m} : {1'b0, m};
        if (OFF == 0) begin
          n.ovf = st[i-1].nn >= {1'b0, st[i-1].c[LN], 31'd0};
          n.q   = '0;
        end else if (OFF == DL - 1) begin
          n.mag = m;
          if (LN == 0) begin
            n.px = sv;
          end else begin
            n.py = sv;
          end
        end else if (st[i-1].nn >= dk) begin
          n.nn   = st[i-1].nn - dk;
          n.q[K] = 1'b1;
        end
      end
    end else if (i == P_Q0) begin : g_q0
      always_comb begin
        n    = st[i-1];
        n.sa = 62'(focal_length) * 62'(focal_length);
        n.sb = 62'(st[i-1].mag) * 62'(st[i-1].mag);
      end
    end else if (i == P_Q1) begin : g_q1
      always_comb begin
        n    = st[i-1];
        n.sa = st[i-1].sa + st[i-1].sb;
        n.sr = '0;
      end
    end else if (i >= P_S && i < P_S + SL) begin : g_sq
      localparam int K = 30 - (i - P_S);
      logic [61:0] b;
      logic [61:0] tr;
      always_comb begin
        n  = st[i-1];
        b  = 62'd1 << (2 * K);
        tr = st[i-1].sr + b;
        if (st[i-1].sa >= tr) begin
          n.sa = st[i-1].sa - tr;
          n.sr = (st[i-1].sr >> 1) + b;
        end else begin
          n.sr = st[i-1].sr >> 1;
        end
      end
    end else if (i == P_U1) begin : g_u1
      always_comb begin
        n    = st[i-1];
        n.nn = 64'(st[i-1].sr[31:0]) * 64'(st[i-1].s[1]);
      end
    end else begin : g_out
      logic signed [32:0] sx;
      logic signed [32:0] sy;
      always_comb begin
        n      = st[i-1];
        sx     = $signed({17'd0, centre_x}) + $signed({st[i-1].px[31], st[i-1].px});
        sy     = $signed({17'd0, centre_y}) + $signed({st[i-1].py[31], st[i-1].py});
        n.clip = 1'b0;
        n.ox   = sx[23:0];
        n.oy   = sy[23:0];
        if (sx > C_PMAX) begin
          n.ox   = C_PMAX[23:0];
          n.clip = 1'b1;
        end else if (sx < C_PMIN) begin
          n.ox   = C_PMIN[23:0];
          n.clip = 1'b1;
        end
        if (sy > C_PMAX) begin
          n.oy   = C_PMAX[23:0];
          n.clip = 1'b1;
        end else if (sy < C_PMIN) begin
          n.oy   = C_PMIN[23:0];
          n.clip = 1'b1;
        end
        if (!st[i-1].inview) begin
          n.ox   = '0;
          n.oy   = '0;
          n.clip = 1'b0;
        end
      end
    end
  end

  assign out_valid = vld[NSTG-1];
  assign pixel_x   = st[NSTG-1].ox;
  assign pixel_y   = st[NSTG-1].oy;
  assign in_view   = st[NSTG-1].inview;
  assign clipped   = st[NSTG-1].clip;

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat after reset");

  a_out_of_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_view |-> pixel_x == '0 && pixel_y == '0 && !clipped)
    else $error("rejected ray with nonzero result");

  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> pixel_x == 24'sh7fffff || pixel_x == -24'sh800000 ||
                             pixel_y == 24'sh7fffff || pixel_y == -24'sh800000)
    else $error("clipped without a saturated coordinate");

endmodule
